// File: hw/rtl/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// Shared widths, operation codes and status codes of the chained hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package cht_pkg;

  // payload field widths
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;

  // stream data widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 40;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIND   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

endpackage

`default_nettype wire

// File: hw/rtl/cht_hash.sv
// ----------------------------------------------------------------------------
// cht_hash
// Iterative key modulo bucket-count unit, four key bits per cycle,
// most significant bits first (restoring remainder).
// ----------------------------------------------------------------------------
`default_nettype none

module cht_hash #(
  parameter int unsigned NUM_BUCKETS = 16,
  parameter int unsigned REM_W       = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [cht_pkg::KEY_W-1:0] key_i,
  output logic                      done_o,
  output logic [REM_W-1:0]          rem_o
);
  import cht_pkg::*;

  localparam int unsigned CMP_W         = REM_W + 1;
  localparam int unsigned BITS_PER_STEP = 4;
  localparam int unsigned NUM_STEPS     = KEY_W / BITS_PER_STEP;
  localparam int unsigned CNT_W         = $clog2(NUM_STEPS);
  localparam logic [CMP_W-1:0] MOD_C    = CMP_W'(NUM_BUCKETS);
  localparam logic [CNT_W-1:0] LAST_C   = CNT_W'(NUM_STEPS - 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [KEY_W-1:0] sh_q, sh_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [CMP_W-1:0] r, t;

  // one digit of the remainder: shift in four bits, subtract when over
  always_comb begin
    r = {1'b0, rem_q};
    t = '0;
    for (int j = 0; j < BITS_PER_STEP; j++) begin
      t = {r[REM_W-1:0], sh_q[KEY_W-1-j]};
      if (t >= MOD_C) begin
        t = t - MOD_C;
      end
      r = t;
    end
  end

  // next state of the iteration
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sh_d   = key_i;
      rem_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + CNT_W'(1);
      sh_d  = sh_q << BITS_PER_STEP;
      rem_d = r[REM_W-1:0];
      if (cnt_q == LAST_C) begin
        busy_d = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign done_o = busy_q && (cnt_q == LAST_C);
  assign rem_o  = r[REM_W-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/cht_entry_mem.sv
// ----------------------------------------------------------------------------
// cht_entry_mem
// Key and value store for all bucket slots, one write and one registered
// read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cht_entry_mem #(
  parameter int unsigned DEPTH  = 128,
  parameter int unsigned ADDR_W = 7
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [ADDR_W-1:0]         waddr_i,
  input  logic [cht_pkg::KEY_W-1:0] wkey_i,
  input  logic [cht_pkg::VAL_W-1:0] wval_i,
  input  logic                      re_i,
  input  logic [ADDR_W-1:0]         raddr_i,
  output logic [cht_pkg::KEY_W-1:0] rkey_o,
  output logic [cht_pkg::VAL_W-1:0] rval_o
);
  import cht_pkg::*;

  logic [KEY_W-1:0] key_mem [DEPTH];
  logic [VAL_W-1:0] val_mem [DEPTH];
  logic [KEY_W-1:0] rkey_q;
  logic [VAL_W-1:0] rval_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[waddr_i] <= wkey_i;
      val_mem[waddr_i] <= wval_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rkey_q <= key_mem[raddr_i];
      rval_q <= val_mem[raddr_i];
    end
  end

  assign rkey_o = rkey_q;
  assign rval_o = rval_q;

endmodule

`default_nettype wire

// File: hw/rtl/cht_fill_mem.sv
// ----------------------------------------------------------------------------
// cht_fill_mem
// Per-bucket entry counts, with a clearing sweep after reset that writes
// zero to one bucket per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cht_fill_mem #(
  parameter int unsigned NUM_BUCKETS = 16,
  parameter int unsigned BKT_W       = 4,
  parameter int unsigned IDX_W       = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [BKT_W-1:0] waddr_i,
  input  logic [IDX_W-1:0] wdata_i,
  input  logic [BKT_W-1:0] raddr_i,
  output logic [IDX_W-1:0] rdata_o,
  output logic             ready_o
);
  import cht_pkg::*;

  localparam logic [BKT_W-1:0] LAST_C = BKT_W'(NUM_BUCKETS - 1);

  logic [IDX_W-1:0] mem [NUM_BUCKETS];
  logic [IDX_W-1:0] rdata_q;
  logic             clr_busy_q, clr_busy_d;
  logic [BKT_W-1:0] clr_idx_q, clr_idx_d;
  logic             mem_we;
  logic [BKT_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_wdata;

  // clearing sweep
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_idx_d  = clr_idx_q;
    if (clr_busy_q) begin
      clr_idx_d = clr_idx_q + BKT_W'(1);
      if (clr_idx_q == LAST_C) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_idx_q  <= clr_idx_d;
    end
  end

  // write port shared by the sweep and the sequencer
  assign mem_we    = clr_busy_q || we_i;
  assign mem_waddr = clr_busy_q ? clr_idx_q : waddr_i;
  assign mem_wdata = clr_busy_q ? '0 : wdata_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
  assign ready_o = !clr_busy_q;

endmodule

`default_nettype wire

// File: hw/rtl/chained_hash_table.sv
// ----------------------------------------------------------------------------
// chained_hash_table
// Key-value table with bounded separate chaining: key modulo bucket count
// selects a bucket, insert appends, find returns the earliest match,
// remove deletes the earliest match and closes the gap.
// ----------------------------------------------------------------------------
//
//  channel  dir  transaction  payload
//  s_axis   in   request      mode, lookup_key, store_value
//  m_axis   out  result       status, found_value
//
//  sequence: after a request is accepted the modulo unit runs, the bucket
//    count is read, and an insert writes its entry unless the bucket is full;
//    find and remove read and check each entry probed, remove moves each
//    later entry up with a read and a write and closes out with the count
//    write; then the result is loaded and the sequencer returns to idle
//  the registered read of the entry store sets the per-entry cost
//  reset: a sweep zeroes the bucket counts one bucket at a time; no request
//    is taken until it ends
//  stalls: a request is taken while the previous result still waits on the
//    output register; the finished result waits for that register to free
//
`default_nettype none

module chained_hash_table #(
  parameter int unsigned NUM_BUCKETS  = 16,
  parameter int unsigned BUCKET_DEPTH = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // mode [1:0], lookup_key [33:2], store_value [65:34], zero [71:66]
  input  logic [cht_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // status [1:0], found_value [33:2], zero [39:34]
  output logic [cht_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i
);
  import cht_pkg::*;

  localparam int unsigned SLOTS  = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int unsigned BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned IDX_W  = $clog2(BUCKET_DEPTH + 1);
  localparam logic [IDX_W-1:0]  DEPTH_C  = IDX_W'(BUCKET_DEPTH);
  localparam logic [ADDR_W-1:0] DEPTH_AC = ADDR_W'(BUCKET_DEPTH);

  // sequencer states
  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_HASH     = 4'd2;
  localparam logic [3:0] S_FILL     = 4'd3;
  localparam logic [3:0] S_DISPATCH = 4'd4;
  localparam logic [3:0] S_SCAN_RD  = 4'd5;
  localparam logic [3:0] S_SCAN_CHK = 4'd6;
  localparam logic [3:0] S_SHIFT_RD = 4'd7;
  localparam logic [3:0] S_SHIFT_WR = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0]          state_q, state_d;
  logic [MODE_W-1:0]   mode_q, mode_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [VAL_W-1:0]    val_q, val_d;
  logic [BKT_W-1:0]    bucket_q, bucket_d;
  logic [ADDR_W-1:0]   base_q, base_d;
  logic [IDX_W-1:0]    fill_q, fill_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [VAL_W-1:0]    res_value_q, res_value_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [VAL_W-1:0]    out_value_q, out_value_d;

  logic                in_accept;
  logic                hash_done;
  logic [BKT_W-1:0]    hash_rem;
  logic                ent_we, ent_re;
  logic [ADDR_W-1:0]   ent_waddr, ent_raddr;
  logic [KEY_W-1:0]    ent_wkey, ent_rkey;
  logic [VAL_W-1:0]    ent_wval, ent_rval;
  logic                fill_we, fill_ready;
  logic [IDX_W-1:0]    fill_wdata, fill_rd;
  logic [IDX_W-1:0]    idx_next;

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign idx_next  = idx_q + IDX_W'(1);

  // modulo unit
  cht_hash #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .REM_W      (BKT_W)
  ) u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_accept),
    .key_i  (s_axis_tdata_i[33:2]),
    .done_o (hash_done),
    .rem_o  (hash_rem)
  );

  // key and value store
  cht_entry_mem #(
    .DEPTH (SLOTS),
    .ADDR_W(ADDR_W)
  ) u_entry_mem (
    .clk_i  (clk_i),
    .we_i   (ent_we),
    .waddr_i(ent_waddr),
    .wkey_i (ent_wkey),
    .wval_i (ent_wval),
    .re_i   (ent_re),
    .raddr_i(ent_raddr),
    .rkey_o (ent_rkey),
    .rval_o (ent_rval)
  );

  // bucket counts
  cht_fill_mem #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .BKT_W      (BKT_W),
    .IDX_W      (IDX_W)
  ) u_fill_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (fill_we),
    .waddr_i(bucket_q),
    .wdata_i(fill_wdata),
    .raddr_i(bucket_q),
    .rdata_o(fill_rd),
    .ready_o(fill_ready)
  );

  // sequencer
  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    key_d        = key_q;
    val_d        = val_q;
    bucket_d     = bucket_q;
    base_d       = base_q;
    fill_d       = fill_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    ent_we       = 1'b0;
    ent_waddr    = base_q + ADDR_W'(idx_q);
    ent_wkey     = ent_rkey;
    ent_wval     = ent_rval;
    ent_re       = 1'b0;
    ent_raddr    = base_q + ADDR_W'(idx_q);
    fill_we      = 1'b0;
    fill_wdata   = fill_q - IDX_W'(1);

    unique case (state_q)
      S_CLEAR: begin
        if (fill_ready) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          mode_d       = s_axis_tdata_i[1:0];
          key_d        = s_axis_tdata_i[33:2];
          val_d        = s_axis_tdata_i[65:34];
          res_status_d = STATUS_ABSENT;
          res_value_d  = '0;
          state_d      = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          bucket_d = hash_rem;
          state_d  = S_FILL;
        end
      end
      S_FILL: begin
        // count read in flight, bucket base computed meanwhile
        base_d  = ADDR_W'(bucket_q) * DEPTH_AC;
        state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        fill_d = fill_rd;
        idx_d  = '0;
        priority if (mode_q == MODE_INSERT) begin
          if (fill_rd >= DEPTH_C) begin
            res_status_d = STATUS_FULL;
          end else begin
            ent_we       = 1'b1;
            ent_waddr    = base_q + ADDR_W'(fill_rd);
            ent_wkey     = key_q;
            ent_wval     = val_q;
            fill_we      = 1'b1;
            fill_wdata   = fill_rd + IDX_W'(1);
            res_status_d = STATUS_OK;
          end
          state_d = S_DONE;
        end else if (mode_q == MODE_FIND || mode_q == MODE_REMOVE) begin
          state_d = S_SCAN_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SCAN_RD: begin
        if (idx_q >= fill_q) begin
          state_d = S_DONE;
        end else begin
          ent_re  = 1'b1;
          state_d = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (ent_rkey == key_q) begin
          if (mode_q == MODE_FIND) begin
            res_status_d = STATUS_OK;
            res_value_d  = ent_rval;
            state_d      = S_DONE;
          end else begin
            state_d = S_SHIFT_RD;
          end
        end else begin
          idx_d   = idx_next;
          state_d = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        // move the following entry up, or close out the remove
        if (idx_next < fill_q) begin
          ent_re    = 1'b1;
          ent_raddr = base_q + ADDR_W'(idx_next);
          state_d   = S_SHIFT_WR;
        end else begin
          fill_we      = 1'b1;
          res_status_d = STATUS_OK;
          state_d      = S_DONE;
        end
      end
      S_SHIFT_WR: begin
        ent_we  = 1'b1;
        idx_d   = idx_next;
        state_d = S_SHIFT_RD;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_value_d  = res_value_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    key_q        <= key_d;
    val_q        <= val_d;
    bucket_q     <= bucket_d;
    base_q       <= base_d;
    fill_q       <= fill_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
  end

  // ports
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_value_q, out_status_q};

  // checks
  a_hash_done_in_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_done |-> (state_q == S_HASH))
    else $error("modulo unit finished outside the hash phase");

  a_entry_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent_we |-> (state_q == S_DISPATCH || state_q == S_SHIFT_WR))
    else $error("entry store written outside insert or shift");

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DISPATCH) |-> (fill_rd <= DEPTH_C))
    else $error("bucket count above bucket depth");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result issued outside the done phase");

endmodule

`default_nettype wire
